FILE: rtl/xcf_pkg.sv
// Shared types and constants for the x86 compare-flags and condition-test block.
// Used by the execute logic and the top level; depends on nothing else.
`timescale 1ns / 1ps

package xcf_pkg;

    // Command codes carried on the command port.
    typedef enum logic [2:0] {
        CMD_CMP  = 3'd0,
        CMD_CMOV = 3'd1,
        CMD_CLC  = 3'd2,
        CMD_CLD  = 3'd3,
        CMD_CMC  = 3'd4,
        CMD_CBW  = 3'd5,
        CMD_CWDE = 3'd6,
        CMD_NOP  = 3'd7
    } cmd_t;

    // Operand width codes; the two remaining codes behave as 32 bits.
    localparam logic [1:0] WIDTH_8  = 2'd0;
    localparam logic [1:0] WIDTH_16 = 2'd1;

    // Condition pairs: the upper three bits of the condition code pick the
    // flag test, the low bit inverts it.
    localparam logic [2:0] CC_O  = 3'd0;
    localparam logic [2:0] CC_B  = 3'd1;
    localparam logic [2:0] CC_E  = 3'd2;
    localparam logic [2:0] CC_BE = 3'd3;
    localparam logic [2:0] CC_S  = 3'd4;
    localparam logic [2:0] CC_P  = 3'd5;
    localparam logic [2:0] CC_L  = 3'd6;
    localparam logic [2:0] CC_LE = 3'd7;

    // Auxiliary flag comes from the borrow into bit four.
    localparam int AUX_POS = 4;

    typedef struct packed {
        logic cf;
        logic pf;
        logic af;
        logic zf;
        logic sf;
        logic of;
        logic df;
    } flags_t;

    typedef struct packed {
        logic [31:0] value;
        logic        taken;
        flags_t      flags;
    } exec_result_t;

endpackage

FILE: rtl/x86_compare_flags_and_condition_test.sv
// x86 status-flag block: compare, conditional-move test, flag commands, sign widening.
//
// Usage:
//   The input channel (in_valid / in_ready) carries one command beat with its
//   operands. The output channel (out_valid / out_ready) returns exactly one
//   beat per command: result_value, move_taken and all seven flags as they
//   stand after that command.
//   The accepted beat is held in the input register, then the execute logic
//   feeds the result register, whose valid drives out_valid. Throughput is
//   one beat per cycle while out_ready stays high. The flag register is
//   updated as a beat moves from the input register into the result register,
//   so every command sees the flags left by the one before it with no bubble.
//   When the receiver stalls, the result register holds its beat, the input
//   register still takes one more beat, and in_ready then drops until the
//   result is taken.
//   Reset clears both pipeline valids and all seven flags.
// Depends on xcf_pkg and xcf_exec.
`timescale 1ns / 1ps

module x86_compare_flags_and_condition_test
    import xcf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  command,
    input  logic [1:0]  width_code,
    input  logic [31:0] operand_a,
    input  logic [31:0] operand_b,
    input  logic        extend_b,
    input  logic [3:0]  condition,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] result_value,
    output logic        move_taken,
    output logic        carry_flag,
    output logic        parity_flag,
    output logic        aux_flag,
    output logic        zero_flag,
    output logic        sign_flag,
    output logic        overflow_flag,
    output logic        direction_flag
);

    logic         in_valid_reg;
    logic [2:0]   command_reg;
    logic [1:0]   width_code_reg;
    logic [31:0]  operand_a_reg;
    logic [31:0]  operand_b_reg;
    logic         extend_b_reg;
    logic [3:0]   condition_reg;
    logic         out_valid_reg;
    exec_result_t result_reg;
    flags_t       flags_reg;
    flags_t       flags_next;
    exec_result_t exec_out;
    logic         advance;
    logic         in_fire;

    // Pipeline handshake.
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;
    assign in_fire  = in_valid && in_ready;

    xcf_exec u_exec (
        .command    (command_reg),
        .width_code (width_code_reg),
        .operand_a  (operand_a_reg),
        .operand_b  (operand_b_reg),
        .extend_b   (extend_b_reg),
        .condition  (condition_reg),
        .flags_in   (flags_reg),
        .result     (exec_out)
    );

    assign flags_next = advance ? exec_out.flags : flags_reg;

    // Control state: valids and the architectural flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            flags_reg     <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            flags_reg <= flags_next;
        end
    end

    // Input payload register.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            command_reg    <= command;
            width_code_reg <= width_code;
            operand_a_reg  <= operand_a;
            operand_b_reg  <= operand_b;
            extend_b_reg   <= extend_b;
            condition_reg  <= condition;
        end
    end

    // Result payload register.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= exec_out;
        end
    end

    assign out_valid      = out_valid_reg;
    assign result_value   = result_reg.value;
    assign move_taken     = result_reg.taken;
    assign carry_flag     = result_reg.flags.cf;
    assign parity_flag    = result_reg.flags.pf;
    assign aux_flag       = result_reg.flags.af;
    assign zero_flag      = result_reg.flags.zf;
    assign sign_flag      = result_reg.flags.sf;
    assign overflow_flag  = result_reg.flags.of;
    assign direction_flag = result_reg.flags.df;

endmodule

FILE: rtl/xcf_exec.sv
// Single-pass execute logic: compare, condition test, flag commands and widening.
// Depends on xcf_pkg for command codes, condition codes and the flag struct.
`timescale 1ns / 1ps

module xcf_exec
    import xcf_pkg::*;
(
    input  logic [2:0]   command,
    input  logic [1:0]   width_code,
    input  logic [31:0]  operand_a,
    input  logic [31:0]  operand_b,
    input  logic         extend_b,
    input  logic [3:0]   condition,
    input  flags_t       flags_in,
    output exec_result_t result
);

    logic [31:0] mask;
    logic [31:0] op1;
    logic [31:0] op2;
    logic [32:0] diff_wide;
    logic [31:0] diff;
    logic        s1;
    logic        s2;
    logic        sd;
    logic        cond_base;
    logic        cond_ok;
    cmd_t        cmd;

    assign cmd = cmd_t'(command);

    // Width mask for the operand size.
    always_comb
    begin
        case (width_code)
            WIDTH_8:  mask = 32'h0000_00FF;
            WIDTH_16: mask = 32'h0000_FFFF;
            default:  mask = 32'hFFFF_FFFF;
        endcase
    end

    // Compare subtract; the extra top bit of the wide difference is the borrow.
    always_comb
    begin
        op1 = operand_a & mask;
        if (extend_b)
        begin
            op2 = {{24{operand_b[7]}}, operand_b[7:0]} & mask;
        end
        else
        begin
            op2 = operand_b & mask;
        end
        diff_wide = {1'b0, op1} - {1'b0, op2};
        diff      = diff_wide[31:0] & mask;
    end

    // Sign bits at the operand width.
    always_comb
    begin
        case (width_code)
            WIDTH_8:
            begin
                s1 = op1[7];
                s2 = op2[7];
                sd = diff[7];
            end
            WIDTH_16:
            begin
                s1 = op1[15];
                s2 = op2[15];
                sd = diff[15];
            end
            default:
            begin
                s1 = op1[31];
                s2 = op2[31];
                sd = diff[31];
            end
        endcase
    end

    // Condition test against the flags held before this beat.
    always_comb
    begin
        case (condition[3:1])
            CC_O:    cond_base = flags_in.of;
            CC_B:    cond_base = flags_in.cf;
            CC_E:    cond_base = flags_in.zf;
            CC_BE:   cond_base = flags_in.cf | flags_in.zf;
            CC_S:    cond_base = flags_in.sf;
            CC_P:    cond_base = flags_in.pf;
            CC_L:    cond_base = flags_in.sf ^ flags_in.of;
            CC_LE:   cond_base = flags_in.zf | (flags_in.sf ^ flags_in.of);
            default: cond_base = 1'b0;
        endcase
        cond_ok = cond_base ^ condition[0];
    end

    // Command decode: result value, move flag and updated flags.
    always_comb
    begin
        result.value = '0;
        result.taken = 1'b0;
        result.flags = flags_in;
        unique case (cmd)
            CMD_CMP:
            begin
                result.value    = diff;
                result.flags.cf = diff_wide[32];
                result.flags.of = (s1 != s2) && (sd == s2);
                result.flags.sf = sd;
                result.flags.zf = (diff == '0);
                result.flags.af = op1[AUX_POS] ^ op2[AUX_POS] ^ diff[AUX_POS];
                result.flags.pf = ~^diff[7:0];
            end
            CMD_CMOV:
            begin
                result.taken = cond_ok;
                result.value = (cond_ok ? operand_b : operand_a) & mask;
            end
            CMD_CLC:
            begin
                result.flags.cf = 1'b0;
            end
            CMD_CLD:
            begin
                result.flags.df = 1'b0;
            end
            CMD_CMC:
            begin
                result.flags.cf = ~flags_in.cf;
            end
            CMD_CBW:
            begin
                result.value = {16'h0000, {8{operand_a[7]}}, operand_a[7:0]};
            end
            CMD_CWDE:
            begin
                result.value = {{16{operand_a[15]}}, operand_a[15:0]};
            end
            default:
            begin
                result.value = '0;
            end
        endcase
    end

endmodule

FILE: rtl/xcf_checker.sv
// Port-level checks for the x86 compare-flags block, bound to the top level.
// Sees only the top-level ports; no package needed.
`timescale 1ns / 1ps

module xcf_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] result_value,
    input logic        carry_flag,
    input logic        parity_flag,
    input logic        aux_flag,
    input logic        zero_flag,
    input logic        sign_flag,
    input logic        overflow_flag,
    input logic        direction_flag
);

    // A stalled result beat stays put.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(result_value))
        else $error("result beat changed while stalled");

    // No command ever sets the direction flag, and it resets to zero.
    a_df_clear: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !direction_flag)
        else $error("direction flag set");

    // Zero is only set by a compare with equal operands, which also fixes
    // parity, auxiliary, sign and overflow; later commands keep them.
    a_zero_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && zero_flag |-> parity_flag && !aux_flag && !sign_flag && !overflow_flag)
        else $error("flags inconsistent with zero flag");

    // With no result waiting the block must take input.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output");

    // A beat taken with an empty output passes the input and result registers and raises out_valid.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !out_valid |=> ##1 out_valid)
        else $error("result beat missing after accept");

endmodule

bind x86_compare_flags_and_condition_test xcf_checker u_xcf_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .result_value   (result_value),
    .carry_flag     (carry_flag),
    .parity_flag    (parity_flag),
    .aux_flag       (aux_flag),
    .zero_flag      (zero_flag),
    .sign_flag      (sign_flag),
    .overflow_flag  (overflow_flag),
    .direction_flag (direction_flag)
);
